[sv/ejm_pkg.sv]
// Shared types and constants for the Euler-angle joint matrix block.
package ejm_pkg;

    localparam logic [1:0] LAST_ROW_IDX = 2'd3;

    typedef struct packed {
        logic        [15:0] angle_x;
        logic        [15:0] angle_y;
        logic        [15:0] angle_z;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } t_item;

    typedef struct packed {
        logic        [1:0]  row_index;
        logic signed [31:0] elem0;
        logic signed [31:0] elem1;
        logic signed [31:0] elem2;
        logic signed [31:0] elem3;
        logic               last_row;
    } t_result;

endpackage

[sv/euler_joint_matrix_fixed.sv]
// Top level: Euler angles and position to a 4x4 affine joint matrix in 15.16 fixed point.
//
// Input channel: an item (three angles, 65536 units per turn, and an integer
// position) is taken at a rising edge where start is high and busy is low.
// Output channel: four row results per item, row 0 first, on consecutive
// cycles, each marked by o_strobe for one cycle; last_row flags row 3.
// The item rate is set by the single output port that carries one row per
// cycle; busy goes high after each accepted transaction and holds off the
// next item, which can still enter before the rows of the previous item have
// all left. The datapath behind it is a six-stage pipeline:
// address, quarter-wave table read, two-factor products, three-factor
// products, sums, rounding toward zero and row assembly, then the row
// serialiser. Rows that reach the serialiser never collide with the next item.
// Reset (synchronous, active low) empties the pipeline and the serialiser and
// drops busy; the sine table is constant and needs no fill.
// The receiver cannot stall: every strobed row is taken at the edge ending it.
module euler_joint_matrix_fixed #(
    parameter int SINE_TABLE_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ejm_pkg::t_item    i_item,
    output logic              busy,
    output logic              o_strobe,
    output ejm_pkg::t_result  o_result
);

    typedef struct packed {
        logic signed [31:0] e00;
        logic signed [31:0] e01;
        logic signed [31:0] e02;
        logic signed [31:0] e12;
        logic signed [31:0] e22;
    } t_twofac;

    function automatic logic signed [31:0] div14(input logic signed [31:0] v);
        logic signed [31:0] b;
        b = v + (v[31] ? 32'sd16383 : 32'sd0);
        return b >>> 14;
    endfunction

    function automatic logic signed [31:0] div29(input logic signed [47:0] v);
        logic signed [47:0] b;
        b = v + (v[47] ? 48'sd536870911 : 48'sd0);
        b = b >>> 29;
        return b[31:0];
    endfunction

    function automatic logic signed [47:0] ext48(input logic signed [31:0] v);
        return {{16{v[31]}}, v};
    endfunction

    logic               accept;
    logic [1:0]         r_gap;
    logic [5:0]         r_vld;
    logic [47:0]        r_pos [5];

    logic signed [15:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;

    logic signed [31:0] r_cycz, r_cysz, r_sxcy, r_cxcy, r_sxsy, r_cxsy;
    logic signed [31:0] r_cxsz, r_cxcz, r_sxsz, r_sxcz;
    logic signed [15:0] r_cz2, r_sz2;
    logic signed [17:0] r_m02;

    logic signed [47:0] r_sxsycz, r_sxsysz, r_cxsycz, r_cxsysz;
    logic signed [31:0] r_cxsz3, r_cxcz3, r_sxsz3, r_sxcz3;
    t_twofac            r_tf3;

    logic signed [47:0] r_s10, r_s11, r_s20, r_s21;
    t_twofac            r_tf4;

    logic [3:0][3:0][31:0] r_mat;

    logic [1:0]         r_cnt;
    logic               r_act;
    logic [1:0]         n_cnt;
    logic               n_act;
    logic [1:0]         sel;
    logic               fire;
    ejm_pkg::t_result   n_out;
    ejm_pkg::t_result   r_out;
    logic               r_strobe;

    assign accept = start && !busy;
    assign busy   = (r_gap != 2'd0);

    ejm_sincos #(.TABLE_BITS(SINE_TABLE_BITS)) u_sc_x (
        .i_clk(i_clk), .i_angle(i_item.angle_x), .o_sin(w_sx), .o_cos(w_cx)
    );
    ejm_sincos #(.TABLE_BITS(SINE_TABLE_BITS)) u_sc_y (
        .i_clk(i_clk), .i_angle(i_item.angle_y), .o_sin(w_sy), .o_cos(w_cy)
    );
    ejm_sincos #(.TABLE_BITS(SINE_TABLE_BITS)) u_sc_z (
        .i_clk(i_clk), .i_angle(i_item.angle_z), .o_sin(w_sz), .o_cos(w_cz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 2'd0;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], accept};
            if (accept) begin
                r_gap <= 2'd3;
            end else if (r_gap != 2'd0) begin
                r_gap <= r_gap - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos[0] <= {i_item.pos_x, i_item.pos_y, i_item.pos_z};
        for (int k = 1; k < 5; k++) begin
            r_pos[k] <= r_pos[k-1];
        end

        r_cycz <= w_cy * w_cz;
        r_cysz <= w_cy * w_sz;
        r_sxcy <= w_sx * w_cy;
        r_cxcy <= w_cx * w_cy;
        r_sxsy <= w_sx * w_sy;
        r_cxsy <= w_cx * w_sy;
        r_cxsz <= w_cx * w_sz;
        r_cxcz <= w_cx * w_cz;
        r_sxsz <= w_sx * w_sz;
        r_sxcz <= w_sx * w_cz;
        r_cz2  <= w_cz;
        r_sz2  <= w_sz;
        r_m02  <= -({{2{w_sy[15]}}, w_sy} <<< 1);

        r_sxsycz  <= r_sxsy * r_cz2;
        r_sxsysz  <= r_sxsy * r_sz2;
        r_cxsycz  <= r_cxsy * r_cz2;
        r_cxsysz  <= r_cxsy * r_sz2;
        r_cxsz3   <= r_cxsz;
        r_cxcz3   <= r_cxcz;
        r_sxsz3   <= r_sxsz;
        r_sxcz3   <= r_sxcz;
        r_tf3.e00 <= div14(r_cycz);
        r_tf3.e01 <= div14(r_cysz);
        r_tf3.e02 <= {{14{r_m02[17]}}, r_m02};
        r_tf3.e12 <= div14(r_sxcy);
        r_tf3.e22 <= div14(r_cxcy);

        r_s10 <= r_sxsycz - (ext48(r_cxsz3) <<< 15);
        r_s11 <= r_sxsysz + (ext48(r_cxcz3) <<< 15);
        r_s20 <= r_cxsycz + (ext48(r_sxsz3) <<< 15);
        r_s21 <= r_cxsysz - (ext48(r_sxcz3) <<< 15);
        r_tf4 <= r_tf3;

        if (r_vld[4]) begin
            r_mat[0] <= {32'(0), r_tf4.e02, r_tf4.e01, r_tf4.e00};
            r_mat[1] <= {32'(0), r_tf4.e12, div29(r_s11), div29(r_s10)};
            r_mat[2] <= {32'(0), r_tf4.e22, div29(r_s21), div29(r_s20)};
            r_mat[3] <= {32'h0001_0000, r_pos[4][15:0], 16'h0000,
                         r_pos[4][31:16], 16'h0000, r_pos[4][47:32], 16'h0000};
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        n_act = r_act;
        sel   = 2'd0;
        fire  = r_act || r_vld[5];
        if (r_act) begin
            sel   = r_cnt;
            n_cnt = r_cnt + 2'd1;
            n_act = (r_cnt != ejm_pkg::LAST_ROW_IDX);
        end else if (r_vld[5]) begin
            n_cnt = 2'd1;
            n_act = 1'b1;
        end
        n_out.row_index = sel;
        n_out.elem0     = r_mat[sel][0];
        n_out.elem1     = r_mat[sel][1];
        n_out.elem2     = r_mat[sel][2];
        n_out.elem3     = r_mat[sel][3];
        n_out.last_row  = (sel == ejm_pkg::LAST_ROW_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_act    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_act    <= n_act;
            r_strobe <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> !r_act)
        else $error("new matrix arrived while rows still being sent");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.row_index != ejm_pkg::LAST_ROW_IDX) |=>
        (o_strobe && o_result.row_index == $past(o_result.row_index) + 2'd1))
        else $error("row sequence broken");

    a_busy_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !(r_vld[0] || r_vld[1] || r_vld[2]))
        else $error("busy released too early");

endmodule

[sv/ejm_sincos.sv]
// Sine and cosine lookup from a quarter-wave Q1.15 table, two register stages.
module ejm_sincos #(
    parameter int TABLE_BITS = 12
) (
    input  logic               i_clk,
    input  logic        [15:0] i_angle,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);

    localparam int QLEN = 1 << (TABLE_BITS - 2);
    localparam int AW   = TABLE_BITS - 1;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [AW-1:0] QLEN_A    = AW'(QLEN);
    localparam logic [63:0] SERIES_DIV [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef logic [QLEN:0][15:0] t_qtab;

    function automatic t_qtab build_qtab();
        t_qtab              tab;
        logic        [63:0] x;
        logic        [63:0] x2;
        logic        [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        tab = '0;
        for (int i = 0; i <= QLEN; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) >> (TABLE_BITS - 2);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int k = 1; k <= 12; k++) begin
                term = ((term * x2) >> 30) / SERIES_DIV[k-1];
                if (k[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > $signed(ONE_Q30)) begin
                sum = $signed(ONE_Q30);
            end
            v = (sum + 64'sd16384) >>> 15;
            if (v > 64'sd32767) begin
                v = 64'sd32767;
            end
            tab[i] = v[15:0];
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    logic [TABLE_BITS-1:0] idx;
    logic [1:0]            quad_s;
    logic [1:0]            quad_c;
    logic [AW-1:0]         frac;
    logic [AW-1:0]         n_addr_s;
    logic [AW-1:0]         n_addr_c;
    logic [AW-1:0]         r_addr_s;
    logic [AW-1:0]         r_addr_c;
    logic                  r_neg_s;
    logic                  r_neg_c;
    logic [15:0]           mag_s;
    logic [15:0]           mag_c;
    logic signed [15:0]    r_sin;
    logic signed [15:0]    r_cos;

    always_comb begin
        idx      = i_angle[15 -: TABLE_BITS];
        quad_s   = idx[TABLE_BITS-1 -: 2];
        quad_c   = quad_s + 2'd1;
        frac     = {1'b0, idx[TABLE_BITS-3:0]};
        n_addr_s = quad_s[0] ? (QLEN_A - frac) : frac;
        n_addr_c = quad_c[0] ? (QLEN_A - frac) : frac;
        mag_s    = QTAB[r_addr_s];
        mag_c    = QTAB[r_addr_c];
    end

    always_ff @(posedge i_clk) begin
        r_addr_s <= n_addr_s;
        r_addr_c <= n_addr_c;
        r_neg_s  <= quad_s[1];
        r_neg_c  <= quad_c[1];
        r_sin    <= r_neg_s ? -$signed(mag_s) : $signed(mag_s);
        r_cos    <= r_neg_c ? -$signed(mag_c) : $signed(mag_c);
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
